/* rtl/khi_pkg.sv */
// Shared types and constants for the keyed hash index unit.
package khi_pkg;

  typedef logic [63:0] word_t;
  typedef logic [3:0][63:0] mix_t;
  typedef logic [7:0] cfg_idx_t;

  localparam int ROUNDS = 11;

  localparam word_t MIX_CONST = 64'hdeadbeefdeadbeef;
  localparam word_t LEN_WORD  = 64'h0800000000000000;

  typedef int unsigned rot_tab_t [0:ROUNDS-1];
  localparam rot_tab_t ROT_AMOUNT = '{15, 52, 26, 51, 28, 9, 47, 54, 32, 25, 63};

  localparam cfg_idx_t REG_SEED_FIRST   = 8'd0;
  localparam cfg_idx_t REG_SEED_SECOND  = 8'd1;
  localparam cfg_idx_t REG_BUCKET_COUNT = 8'd2;
  localparam cfg_idx_t REG_TABLE_SIZE   = 8'd3;

endpackage

/* rtl/khi_if.sv */
// Request and response channel interfaces of the keyed hash index unit.
interface khi_req_if;
  logic        valid;
  logic        ready;
  logic [63:0] key;
  modport source (output valid, output key, input ready);
  modport sink (input valid, input key, output ready);
endinterface

interface khi_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] bucket_index;
  logic [31:0] slot_base;
  logic [31:0] slot_step;
  modport source (output valid, output bucket_index, output slot_base, output slot_step,
                  input ready);
  modport sink (input valid, input bucket_index, input slot_base, input slot_step,
                output ready);
endinterface

/* rtl/keyed_hash_index_unit.sv */
// Top level: pipelined keyed hash end mix with bucket and slot reduction.
//
// One key per cycle enters a 76-stage pipeline while the skid register is empty:
// one stage loads the four mixing words (seeds, key plus the fixed constant,
// length word plus the constant), eleven stages each run one xor/rotate/add
// round, and sixty-four stages run a restoring divider one quotient bit per
// stage, three lanes side by side (word zero by bucket_count, words one and two
// by table_size); throughput is one request per cycle. A two-entry output
// (response register plus skid register) lets the pipeline keep moving after the
// consumer stalls until a result is parked in skid; the request side drops ready
// only while the skid register holds a result. A zero modulus gives a zero field.
// Registers are written through cfg_we/cfg_index/cfg_data by the user only while
// no request is in flight (not enforced here); unknown indexes are dropped.
module keyed_hash_index_unit #(
  parameter int INDEX_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  khi_pkg::cfg_idx_t cfg_index,
  input  khi_pkg::word_t    cfg_data,
  khi_req_if.sink           req,
  khi_rsp_if.source         rsp
);
  import khi_pkg::*;

  localparam int DIVS   = 64;
  localparam int NSTAGE = 1 + ROUNDS + DIVS;
  localparam int OUT_BITS = (INDEX_BITS < 32) ? INDEX_BITS : 32;
  localparam logic [31:0] OUT_MASK = 32'((64'd1 << OUT_BITS) - 64'd1);

  typedef struct packed {
    logic [31:0] bucket_index;
    logic [31:0] slot_base;
    logic [31:0] slot_step;
  } rsp_t;

  function automatic word_t rotl(input word_t x, input int unsigned r);
    rotl = (x << r) | (x >> (64 - r));
  endfunction

  function automatic mix_t mix_round(input mix_t h, input int i);
    mix_t o;
    int   a;
    int   b;
    o = h;
    a = (i + 3) % 4;
    b = (i + 2) % 4;
    o[a] = o[a] ^ o[b];
    o[b] = rotl(o[b], ROT_AMOUNT[i]);
    o[a] = o[a] + o[b];
    mix_round = o;
  endfunction

  // configuration registers
  word_t       seed_first;
  word_t       seed_second;
  logic [31:0] bucket_count;
  logic [31:0] table_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_first   <= '0;
      seed_second  <= '0;
      bucket_count <= 32'd1;
      table_size   <= 32'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEED_FIRST:   seed_first   <= cfg_data;
        REG_SEED_SECOND:  seed_second  <= cfg_data;
        REG_BUCKET_COUNT: bucket_count <= cfg_data[31:0];
        REG_TABLE_SIZE:   table_size   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // pipeline control: advance whenever the skid register is empty
  logic              skid_valid;
  rsp_t              skid_data;
  logic              out_valid;
  rsp_t              out_data;
  logic              adv;
  logic [NSTAGE-1:0] vld;

  assign adv       = !skid_valid;
  assign req.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTAGE-2:0], req.valid};
    end
  end

  // mix stages: stage 0 loads the words, stages 1..ROUNDS run one round each
  mix_t hs [0:ROUNDS];

  always_ff @(posedge clk) begin
    if (adv) begin
      hs[0] <= {LEN_WORD + MIX_CONST, MIX_CONST + req.key, seed_second, seed_first};
    end
  end

  for (genvar r = 1; r <= ROUNDS; r++) begin : g_round
    always_ff @(posedge clk) begin
      if (adv) begin
        hs[r] <= mix_round(hs[r-1], r - 1);
      end
    end
  end

  // divider lanes: 0 = word zero by bucket_count, 1/2 = words one/two by table_size
  logic [2:0][31:0] rm [0:DIVS];
  logic [2:0][63:0] nm [0:DIVS];
  logic [2:0][31:0] dv;

  assign dv    = {table_size, table_size, bucket_count};
  assign rm[0] = '0;
  assign nm[0] = {hs[ROUNDS][2], hs[ROUNDS][1], hs[ROUNDS][0]};

  for (genvar k = 1; k <= DIVS; k++) begin : g_div
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [32:0] trial;
      assign trial = {rm[k-1][l], nm[k-1][l][63]};
      always_ff @(posedge clk) begin
        if (adv) begin
          // restoring step: subtract the divisor when it fits
          if (trial >= {1'b0, dv[l]}) begin
            rm[k][l] <= 32'(trial - {1'b0, dv[l]});
          end else begin
            rm[k][l] <= trial[31:0];
          end
          nm[k][l] <= {nm[k-1][l][62:0], 1'b0};
        end
      end
    end
  end

  rsp_t res;
  always_comb begin
    res.bucket_index = (bucket_count == '0) ? '0 : (rm[DIVS][0] & OUT_MASK);
    res.slot_base    = (table_size == '0) ? '0 : (rm[DIVS][1] & OUT_MASK);
    res.slot_step    = (table_size == '0) ? '0 : (rm[DIVS][2] & OUT_MASK);
  end

  // response register with skid: hold the waiting result, park one more in skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (rsp.ready) begin
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || rsp.ready) begin
      out_valid <= vld[NSTAGE-1];
    end else if (vld[NSTAGE-1]) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (rsp.ready) begin
        out_data <= skid_data;
      end
    end else if (!out_valid || rsp.ready) begin
      out_data <= res;
    end else begin
      skid_data <= res;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.bucket_index = out_data.bucket_index;
  assign rsp.slot_base    = out_data.slot_base;
  assign rsp.slot_step    = out_data.slot_step;

endmodule

/* rtl/khi_checker.sv */
// Port-level checker for the keyed hash index unit, with its bind.
module khi_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [95:0] rsp_payload
);

  a_rst_idle: assert property (@(posedge clk) rst |=> !rsp_valid && req_ready)
    else $error("response valid or request stalled right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> $past(rsp_valid && !rsp_ready))
    else $error("request side stalled without a stalled response");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_payload))
    else $error("response payload changed while stalled");

endmodule

bind keyed_hash_index_unit khi_checker u_khi_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload ({rsp.bucket_index, rsp.slot_base, rsp.slot_step})
);
